// ===== rtl/gsg_pkg.sv =====
// Shared constants, reset values and register codes for the gyro stationary gate.
// Used by the top level and the axis test; depends on nothing else.

package gsg_pkg;

  // Field widths of the stream words and configuration registers.
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned GAIN_W  = 4;
  localparam int unsigned MEAN_W  = 19;
  localparam int unsigned VAR_W   = 40;
  localparam int unsigned RLIM_W  = 19;

  // A kept copy is a rate times a gain of up to four bits.
  localparam int unsigned KEPT_W  = RATE_W + GAIN_W;
  localparam int unsigned PROD_W  = 2 * KEPT_W;

  localparam int unsigned TDATA_W    = ((3 * RATE_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = VAR_W;

  localparam int unsigned DEFAULT_WINDOW = 100;

  localparam logic [MEAN_W-1:0] MEAN_LIMIT_RST = MEAN_W'(262);
  localparam logic [VAR_W-1:0]  VAR_LIMIT_RST  = VAR_W'(4294967);
  localparam logic [RLIM_W-1:0] RATE_LIMIT_RST = RLIM_W'(1311);
  localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_LIMIT,
    CFG_VARIANCE_LIMIT,
    CFG_RATE_LIMIT,
    CFG_HIGH_RATE_GAIN
  } cfg_idx_e;

endpackage

// ===== rtl/gyro_stationary_gate.sv =====
// Top level of the gyro stationary gate: stream ports, ring of kept samples,
// running sums and the output stage. Depends on gsg_pkg, gsg_ram and gsg_axis_test.

// The gate takes one three-axis rate word per clock while the output side does not
// stall and returns one word per input word, in order. A word is accepted in
// every cycle in which the output register is empty or is being emptied, so the
// sustained rate is one word per cycle while the output does not stall; the
// ring of the last WINDOW kept samples sits in one RAM with a separate write and
// registered read port, which is what lets a new word read its oldest entry while
// the previous word writes its own. Each sample whose largest axis magnitude
// exceeds rate_limit is kept for statistics multiplied by high_rate_gain. Once
// WINDOW words have been seen, every word recomputes the still flag from the
// running per-axis sums with exact integer compares; while the flag is set the
// output rates are zero and is_still is one, otherwise the raw rates pass
// through. Before the ring is full the flag stays clear. The ring itself needs no
// clearing after reset, as an entry's contents are used only once it has been written.
// Configuration is written through its own channel, which is always ready, and
// must only be written while no word is in flight.

module gyro_stationary_gate import gsg_pkg::*; #(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rate_x [19:0], rate_y [39:20], rate_z [59:40], zero fill above.
  input  logic [TDATA_W-1:0]    s_axis_tdata,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // gated_x [19:0], gated_y [39:20], gated_z [59:40], zero fill above.
  output logic [TDATA_W-1:0]    m_axis_tdata,
  // is_still [0].
  output logic                  m_axis_tuser,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CLW     = $clog2(WINDOW);
  localparam int unsigned SLOT_W  = CLW;
  localparam int unsigned FILL_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W   = KEPT_W + CLW;
  localparam int unsigned SQ_W    = PROD_W - 1 + CLW;
  localparam int unsigned NMEAN_W = MEAN_W + CLW;
  localparam int unsigned VB_W    = VAR_W + 2 * CLW;
  localparam int unsigned NSTG    = 8;
  localparam int unsigned RAW_W   = 3 * RATE_W;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Configuration registers and the bounds derived from them.
  logic [MEAN_W-1:0]  mean_limit_q;
  logic [VAR_W-1:0]   var_limit_q;
  logic [RLIM_W-1:0]  rate_limit_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [NMEAN_W-1:0] mean_bound_q;
  logic [VB_W-1:0]    var_bound_q;

  // Pipeline control.
  logic              adv;
  logic              in_acc;
  logic [NSTG-1:0]   vld_q;
  logic              out_vld_q;
  logic [RAW_W-1:0]  out_data_q;
  logic              out_still_q;

  // Ring bookkeeping.
  logic [SLOT_W-1:0] write_slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [SLOT_W-1:0] slot_q;
  logic              full_before_q;

  logic [RAW_W-1:0]  raw_pipe_q [NSTG];
  logic [NSTG-1:0]   full_pipe_q;

  // Per-axis datapath.
  logic signed [RATE_W-1:0]  raw1   [3];
  logic        [RATE_W-1:0]  mag1   [3];
  logic                      fast;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [KEPT_W-1:0]  kept_d [3];
  logic signed [KEPT_W-1:0]  old_d  [3];
  logic [3*KEPT_W-1:0]       kept_pack;
  logic [3*KEPT_W-1:0]       ring_rdata;

  logic signed [KEPT_W-1:0]  kept_q  [3];
  logic signed [KEPT_W-1:0]  old_q   [3];
  logic signed [PROD_W-1:0]  ksq_q   [3];
  logic signed [PROD_W-1:0]  osq_q   [3];
  logic signed [KEPT_W:0]    dsum_q  [3];
  logic signed [KEPT_W:0]    dsum4_q [3];
  logic signed [PROD_W-1:0]  dsq_q   [3];

  logic signed [SUM_W-1:0]   sum_q [3];
  logic        [SQ_W-1:0]    sq_q  [3];
  logic        [2:0]         axis_ok;
  logic                      still;

  // The whole pipeline moves as one whenever the output register can take a word.
  assign adv           = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_limit_q <= MEAN_LIMIT_RST;
      var_limit_q  <= VAR_LIMIT_RST;
      rate_limit_q <= RATE_LIMIT_RST;
      gain_q       <= GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MEAN_LIMIT:     mean_limit_q <= cfg_data_i[MEAN_W-1:0];
        CFG_VARIANCE_LIMIT: var_limit_q  <= cfg_data_i[VAR_W-1:0];
        CFG_RATE_LIMIT:     rate_limit_q <= cfg_data_i[RLIM_W-1:0];
        CFG_HIGH_RATE_GAIN: gain_q       <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The bounds are constant multiples of the limits. They are registered from the
  // limit registers after a write, long before a word reaches the compare stage.
  always_ff @(posedge clk_i) begin
    mean_bound_q <= NMEAN_W'(mean_limit_q) * NMEAN_W'(WINDOW);
    var_bound_q  <= VB_W'(var_limit_q) * VB_W'(WINDOW * WINDOW);
  end

  // Control state: valid bits, ring pointer, fill count and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      out_vld_q    <= 1'b0;
      write_slot_q <= '0;
      fill_q       <= '0;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
        sq_q[a]  <= '0;
      end
    end else if (adv) begin
      vld_q     <= {vld_q[NSTG-2:0], in_acc};
      out_vld_q <= vld_q[NSTG-1];
      if (in_acc) begin
        write_slot_q <= (write_slot_q == SLOT_LAST) ? '0 : write_slot_q + 1'b1;
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      // The sums move by the difference between the newest and the evicted copy.
      if (vld_q[3]) begin
        for (int a = 0; a < 3; a++) begin
          sum_q[a] <= sum_q[a] + SUM_W'(dsum4_q[a]);
          sq_q[a]  <= sq_q[a] + SQ_W'(dsq_q[a]);
        end
      end
    end
  end

  // First stage: gain selection and the evicted entry from the ring.
  always_comb begin
    fast = 1'b0;
    for (int a = 0; a < 3; a++) begin
      raw1[a] = raw_pipe_q[0][a*RATE_W +: RATE_W];
      mag1[a] = raw1[a][RATE_W-1] ? RATE_W'(-raw1[a]) : RATE_W'(raw1[a]);
      if (mag1[a] > RATE_W'(rate_limit_q)) begin
        fast = 1'b1;
      end
    end
    gain_s = fast ? $signed({1'b0, gain_q}) : (GAIN_W+1)'(1);
    for (int a = 0; a < 3; a++) begin
      kept_d[a] = KEPT_W'(raw1[a]) * KEPT_W'(gain_s);
      kept_pack[a*KEPT_W +: KEPT_W] = kept_d[a];
      // Until the ring is full nothing is evicted.
      old_d[a] = full_before_q ? $signed(ring_rdata[a*KEPT_W +: KEPT_W]) : '0;
    end
  end

  // The oldest entry is read as a word is accepted and overwritten as it leaves
  // the first stage, so the next word never sees a stale slot.
  gsg_ram #(
    .WIDTH (3 * KEPT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (adv && vld_q[0]),
    .waddr_i (slot_q),
    .wdata_i (kept_pack),
    .re_i    (in_acc),
    .raddr_i (write_slot_q),
    .rdata_o (ring_rdata)
  );

  // Data stages carry no reset; the valid bits say what they hold.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_pipe_q[0]  <= s_axis_tdata[RAW_W-1:0];
      full_pipe_q[0] <= (fill_q == FILL_FULL) || (fill_q == FILL_LAST);
      slot_q         <= write_slot_q;
      full_before_q  <= (fill_q == FILL_FULL);
      for (int i = 1; i < NSTG; i++) begin
        raw_pipe_q[i]  <= raw_pipe_q[i-1];
        full_pipe_q[i] <= full_pipe_q[i-1];
      end
      for (int a = 0; a < 3; a++) begin
        kept_q[a]  <= kept_d[a];
        old_q[a]   <= old_d[a];
        ksq_q[a]   <= PROD_W'(kept_q[a]) * PROD_W'(kept_q[a]);
        osq_q[a]   <= PROD_W'(old_q[a]) * PROD_W'(old_q[a]);
        dsum_q[a]  <= (KEPT_W+1)'(kept_q[a]) - (KEPT_W+1)'(old_q[a]);
        dsq_q[a]   <= ksq_q[a] - osq_q[a];
        dsum4_q[a] <= dsum_q[a];
      end
      out_data_q  <= still ? '0 : raw_pipe_q[NSTG-1];
      out_still_q <= still;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    gsg_axis_test #(
      .WINDOW  (WINDOW),
      .SUM_W   (SUM_W),
      .SQ_W    (SQ_W),
      .NMEAN_W (NMEAN_W),
      .VB_W    (VB_W)
    ) u_test (
      .clk_i        (clk_i),
      .adv_i        (adv),
      .sum_i        (sum_q[g]),
      .sq_i         (sq_q[g]),
      .mean_bound_i (mean_bound_q),
      .var_bound_i  (var_bound_q),
      .ok_o         (axis_ok[g])
    );
  end

  // Once the ring is full the flag is recomputed for every word, so it is a
  // plain function of that word's statistics.
  assign still = full_pipe_q[NSTG-1] && (&axis_ok);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tuser  = out_still_q;

endmodule

// ===== rtl/gsg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the ring of kept samples; depends on nothing else.

module gsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsg_axis_test.sv =====
// Pipelined stillness test for one axis: exact mean and spread compares.
// Depends on gsg_pkg for widths and defaults.

module gsg_axis_test import gsg_pkg::*; #(
  parameter int unsigned WINDOW  = DEFAULT_WINDOW,
  parameter int unsigned SUM_W   = KEPT_W + $clog2(DEFAULT_WINDOW),
  parameter int unsigned SQ_W    = PROD_W - 1 + $clog2(DEFAULT_WINDOW),
  parameter int unsigned NMEAN_W = MEAN_W + $clog2(DEFAULT_WINDOW),
  parameter int unsigned VB_W    = VAR_W + 2 * $clog2(DEFAULT_WINDOW)
) (
  input  logic                    clk_i,
  input  logic                    adv_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [SQ_W-1:0]         sq_i,
  input  logic [NMEAN_W-1:0]      mean_bound_i,
  input  logic [VB_W-1:0]         var_bound_i,
  output logic                    ok_o
);

  localparam int unsigned CLW   = $clog2(WINDOW);
  localparam int unsigned NSQ_W = SQ_W + CLW;
  localparam int unsigned HALF  = (SUM_W + 1) / 2;
  localparam int unsigned HI_W  = SUM_W - HALF;
  localparam int unsigned SSQ_W = 2 * SUM_W;
  localparam int unsigned MW    = (SUM_W > NMEAN_W) ? SUM_W : NMEAN_W;
  localparam int unsigned BIG_W = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
  localparam int unsigned CMP_W = ((BIG_W > VB_W) ? BIG_W : VB_W) + 1;
  localparam logic [NSQ_W-1:0] N_SQ = NSQ_W'(WINDOW);

  logic [SUM_W-1:0] mag_d;
  logic [NSQ_W-1:0] nsq_d;
  logic             mean_ok_d;

  logic [SUM_W-1:0] a_mag_q;
  logic [NSQ_W-1:0] a_nsq_q;
  logic             a_mean_ok_q;

  logic [2*HI_W-1:0]    b_hh_q;
  logic [HI_W+HALF-1:0] b_hl_q;
  logic [2*HALF-1:0]    b_ll_q;
  logic [NSQ_W-1:0]     b_nsq_q;
  logic                 b_mean_ok_q;

  logic [SSQ_W-1:0] c_ssq_q;
  logic [NSQ_W-1:0] c_nsq_q;
  logic             c_mean_ok_q;

  logic [HI_W-1:0] hi;
  logic [HALF-1:0] lo;
  logic [SSQ_W-1:0] ssq_d;

  // First stage: magnitude of the sum, scaled square sum and the mean compare.
  always_comb begin
    mag_d     = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    nsq_d     = NSQ_W'(sq_i) * N_SQ;
    mean_ok_d = MW'(mag_d) < MW'(mean_bound_i);
  end

  // The square of the sum is built from half-width partial products.
  assign hi = a_mag_q[SUM_W-1:HALF];
  assign lo = a_mag_q[HALF-1:0];

  assign ssq_d = (SSQ_W'(b_hh_q) << (2 * HALF)) + (SSQ_W'(b_hl_q) << (HALF + 1))
               + SSQ_W'(b_ll_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_mag_q     <= mag_d;
      a_nsq_q     <= nsq_d;
      a_mean_ok_q <= mean_ok_d;

      b_hh_q      <= (2*HI_W)'(hi) * (2*HI_W)'(hi);
      b_hl_q      <= (HI_W+HALF)'(hi) * (HI_W+HALF)'(lo);
      b_ll_q      <= (2*HALF)'(lo) * (2*HALF)'(lo);
      b_nsq_q     <= a_nsq_q;
      b_mean_ok_q <= a_mean_ok_q;

      c_ssq_q     <= ssq_d;
      c_nsq_q     <= b_nsq_q;
      c_mean_ok_q <= b_mean_ok_q;
    end
  end

  // N*sumsq - sum^2 < N^2*limit, rearranged so nothing can go negative.
  assign ok_o = c_mean_ok_q
              && (CMP_W'(c_nsq_q) < (CMP_W'(c_ssq_q) + CMP_W'(var_bound_i)));

endmodule
